/* hw/rtl/asps_pkg.sv */
// ----------------------------------------------------------------------------
// asps_pkg
// Shared types and constants of the aging priority slice scheduler.
// ----------------------------------------------------------------------------
package asps_pkg;

	localparam int MAX_TASKS_DEF = 16;

	// field widths of the channels
	localparam int SLOT_W  = 4;
	localparam int TIME_W  = 8;
	localparam int CNT_W   = 8;
	localparam int PRIO_W  = 16;
	localparam int BASE_W  = 8;
	localparam int SLICE_W = 4;
	localparam int STEP_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AGING_STEP    = 2'd2;

	localparam logic [BASE_W-1:0]  PRIORITY_BASE_RST = 8'd50;
	localparam logic [SLICE_W-1:0] TIME_SLICE_RST    = 4'd2;
	localparam logic [STEP_W-1:0]  AGING_STEP_RST    = 4'd3;

	// input item modes
	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	// slot status codes
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	typedef struct packed {
		logic [BASE_W-1:0]  priority_base;
		logic [SLICE_W-1:0] time_slice;
		logic [STEP_W-1:0]  aging_step;
	} cfg_t;

	// one task table entry
	typedef struct packed {
		logic [TIME_W-1:0] required_time;
		logic [TIME_W-1:0] time_left;
		logic [TIME_W-1:0] time_used;
		logic [CNT_W-1:0]  times_dispatched;
		logic [PRIO_W-1:0] task_priority;
	} task_rec_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_sts_t;

endpackage

/* hw/rtl/asps_if.sv */
// ----------------------------------------------------------------------------
// asps_if
// Valid/ready channels of the scheduler: task input, result output, config.
// ----------------------------------------------------------------------------
interface asps_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [asps_pkg::SLOT_W-1:0] slot;
	logic [asps_pkg::TIME_W-1:0] need_time;

	modport source (output valid, mode, slot, need_time, input ready);
	modport sink (input valid, mode, slot, need_time, output ready);
endinterface

interface asps_out_if;
	logic                               valid;
	logic                               ready;
	logic [asps_pkg::SLOT_W-1:0]        chosen_slot;
	logic [asps_pkg::TIME_W-1:0]        granted_time;
	logic [asps_pkg::TIME_W-1:0]        remaining_time;
	logic [asps_pkg::TIME_W-1:0]        cpu_time_used;
	logic [asps_pkg::CNT_W-1:0]         dispatch_count;
	logic signed [asps_pkg::PRIO_W-1:0] new_priority;
	logic                               task_finished;
	logic                               nothing_to_run;

	modport source (output valid, chosen_slot, granted_time, remaining_time, cpu_time_used,
		dispatch_count, new_priority, task_finished, nothing_to_run, input ready);
	modport sink (input valid, chosen_slot, granted_time, remaining_time, cpu_time_used,
		dispatch_count, new_priority, task_finished, nothing_to_run, output ready);
endinterface

interface asps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [asps_pkg::CFG_IDX_W-1:0]  index;
	logic [asps_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/asps_cfg.sv */
// ----------------------------------------------------------------------------
// asps_cfg
// Configuration register file: priority base, time slice, aging step.
// ----------------------------------------------------------------------------
module asps_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_valid,
	input  logic [asps_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [asps_pkg::CFG_DATA_W-1:0] wr_data,
	output logic                            wr_ready,
	output asps_pkg::cfg_t                  cfg
);
	import asps_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.priority_base <= PRIORITY_BASE_RST;
			cfg_q.time_slice    <= TIME_SLICE_RST;
			cfg_q.aging_step    <= AGING_STEP_RST;
		end else if (wr_valid) begin
			case (wr_index)
				REG_PRIORITY_BASE: cfg_q.priority_base <= wr_data[BASE_W-1:0];
				REG_TIME_SLICE:    cfg_q.time_slice    <= wr_data[SLICE_W-1:0];
				REG_AGING_STEP:    cfg_q.aging_step    <= wr_data[STEP_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

endmodule

/* hw/rtl/asps_ctrl.sv */
// ----------------------------------------------------------------------------
// asps_ctrl
// Sequencer: accepts items, walks the slot scan, commits the chosen slot.
// ----------------------------------------------------------------------------
module asps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	input  asps_pkg::dp_sts_t   sts,
	output asps_pkg::ctrl_cmd_t cmd
);
	import asps_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		state_nxt      = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_DISPATCH) begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_nxt = S_FIN;
			end
			S_FIN: begin
				// hold until the result register can take the new item
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/asps_dp.sv */
// ----------------------------------------------------------------------------
// asps_dp
// Datapath: slot status flops, task table memory, best-candidate compare,
// slice grant and aging update, result register.
// ----------------------------------------------------------------------------
module asps_dp #(
	parameter int MAX_TASKS = asps_pkg::MAX_TASKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  asps_pkg::ctrl_cmd_t                cmd,
	output asps_pkg::dp_sts_t                  sts,
	input  asps_pkg::cfg_t                     cfg,
	input  logic [asps_pkg::SLOT_W-1:0]        load_slot,
	input  logic [asps_pkg::TIME_W-1:0]        load_need,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [asps_pkg::SLOT_W-1:0]        chosen_slot,
	output logic [asps_pkg::TIME_W-1:0]        granted_time,
	output logic [asps_pkg::TIME_W-1:0]        remaining_time,
	output logic [asps_pkg::TIME_W-1:0]        cpu_time_used,
	output logic [asps_pkg::CNT_W-1:0]         dispatch_count,
	output logic signed [asps_pkg::PRIO_W-1:0] new_priority,
	output logic                               task_finished,
	output logic                               nothing_to_run
);
	import asps_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

	logic [1:0] stat_q [MAX_TASKS];
	task_rec_t  task_mem_q [MAX_TASKS];
	task_rec_t  rd_data_q;
	logic [IW-1:0] rd_idx_q;

	logic          best_found_q;
	logic [IW-1:0] best_idx_q;
	task_rec_t     best_q;

	logic          out_valid_q;
	logic [SLOT_W-1:0] chosen_slot_q;
	logic [TIME_W-1:0] granted_q;
	logic [TIME_W-1:0] remaining_q;
	logic [TIME_W-1:0] used_q;
	logic [CNT_W-1:0]  count_q;
	logic [PRIO_W-1:0] prio_q;
	logic              finished_q;
	logic              idle_run_q;

	logic          load_ok;
	logic [IW-1:0] load_addr;
	task_rec_t     load_rec;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          take;
	logic [TIME_W-1:0] slice;
	logic          partial;
	logic [PRIO_W:0]   aged;
	task_rec_t     upd_rec;
	logic [TIME_W-1:0] granted;

	// ---- load path ----
	assign load_ok   = (32'(load_slot) < MAX_TASKS);
	assign load_addr = IW'(load_slot);

	always_comb begin
		load_rec.required_time    = load_need;
		load_rec.time_left        = load_need;
		load_rec.time_used        = '0;
		load_rec.times_dispatched = '0;
		// base and need are both 8 bit, so the difference never saturates
		load_rec.task_priority    = {{(PRIO_W-BASE_W){1'b0}}, cfg.priority_base}
			- {{(PRIO_W-TIME_W){1'b0}}, load_need};
	end

	// ---- scan: one entry per cycle, read data lines up with rd_idx_q ----
	assign sts.scan_last = (rd_idx_q == LAST_IDX);
	assign rd_en         = cmd.scan_start | (cmd.scan_step & ~sts.scan_last);
	assign rd_addr       = cmd.scan_start ? '0 : rd_idx_q + 1'b1;

	assign take = (stat_q[rd_idx_q] == ST_WAIT) && (!best_found_q
		|| ($signed(rd_data_q.task_priority) > $signed(best_q.task_priority))
		|| ((rd_data_q.task_priority == best_q.task_priority)
			&& (rd_data_q.time_left < best_q.time_left)));

	// ---- update of the chosen entry ----
	assign slice   = (cfg.time_slice == '0) ? TIME_W'(1) : TIME_W'(cfg.time_slice);
	assign partial = (best_q.time_left > slice);
	assign aged    = {best_q.task_priority[PRIO_W-1], best_q.task_priority}
		- {{(PRIO_W+1-STEP_W){1'b0}}, cfg.aging_step};

	always_comb begin
		upd_rec = best_q;
		if (partial) begin
			granted           = slice;
			upd_rec.time_left = best_q.time_left - slice;
			upd_rec.time_used = best_q.time_used + slice;
			if (aged[PRIO_W] != aged[PRIO_W-1])
				upd_rec.task_priority = {1'b1, {(PRIO_W-1){1'b0}}};
			else
				upd_rec.task_priority = aged[PRIO_W-1:0];
		end else begin
			granted           = best_q.time_left;
			upd_rec.time_left = '0;
			upd_rec.time_used = best_q.required_time;
		end
		if (best_q.times_dispatched != {CNT_W{1'b1}})
			upd_rec.times_dispatched = best_q.times_dispatched + 1'b1;
	end

	// ---- task table memory: one write port, one registered read port ----
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok)
			task_mem_q[load_addr] <= load_rec;
		else if (cmd.finish && best_found_q)
			task_mem_q[best_idx_q] <= upd_rec;
		if (rd_en)
			rd_data_q <= task_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++)
				stat_q[i] <= ST_EMPTY;
			rd_idx_q     <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load && load_ok)
				stat_q[load_addr] <= ST_WAIT;
			else if (cmd.finish && best_found_q && !partial)
				stat_q[best_idx_q] <= ST_DONE;

			if (cmd.scan_start) begin
				rd_idx_q     <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (!sts.scan_last)
					rd_idx_q <= rd_idx_q + 1'b1;
				if (take) begin
					best_found_q <= 1'b1;
					best_idx_q   <= rd_idx_q;
				end
			end

			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// best record and result payload
	always_ff @(posedge clk) begin
		if (cmd.scan_step && take)
			best_q <= rd_data_q;
		if (cmd.finish) begin
			if (best_found_q) begin
				chosen_slot_q <= SLOT_W'(best_idx_q);
				granted_q     <= granted;
				remaining_q   <= upd_rec.time_left;
				used_q        <= upd_rec.time_used;
				count_q       <= upd_rec.times_dispatched;
				prio_q        <= upd_rec.task_priority;
				finished_q    <= ~partial;
				idle_run_q    <= 1'b0;
			end else begin
				chosen_slot_q <= '0;
				granted_q     <= '0;
				remaining_q   <= '0;
				used_q        <= '0;
				count_q       <= '0;
				prio_q        <= '0;
				finished_q    <= 1'b0;
				idle_run_q    <= 1'b1;
			end
		end
	end

	assign sts.out_free   = ~out_valid_q | out_ready;
	assign out_valid      = out_valid_q;
	assign chosen_slot    = chosen_slot_q;
	assign granted_time   = granted_q;
	assign remaining_time = remaining_q;
	assign cpu_time_used  = used_q;
	assign dispatch_count = count_q;
	assign new_priority   = $signed(prio_q);
	assign task_finished  = finished_q;
	assign nothing_to_run = idle_run_q;

endmodule

/* hw/rtl/aging_priority_slice_scheduler.sv */
// ----------------------------------------------------------------------------
// aging_priority_slice_scheduler
// Priority scheduler with aging over a table of task slots.
//
//   channel   dir   handshake          payload
//   task_in   in    valid / ready      mode, slot, need_time
//   result    out   valid / ready      chosen_slot .. nothing_to_run
//   cfg       in    valid / ready      index, data
//
// A load item is written into the task table as it is accepted. For a dispatch
// item the slot scan reads one task table entry per cycle through the single
// registered read port, then a commit step writes the update and the result.
// Reset clears the slot status (all empty) and restores the config values.
// The result register lets the next item in while a result waits; a dispatch
// whose result is ready stalls in its commit step until the register frees.
// ----------------------------------------------------------------------------
module aging_priority_slice_scheduler #(
	parameter int MAX_TASKS = asps_pkg::MAX_TASKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	asps_in_if.sink    task_in,
	asps_out_if.source result,
	asps_cfg_if.sink   cfg
);
	import asps_pkg::*;

	cfg_t      cfg_val;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	asps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_val)
	);

	asps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (task_in.valid),
		.in_mode  (task_in.mode),
		.in_ready (task_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asps_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg_val),
		.load_slot      (task_in.slot),
		.load_need      (task_in.need_time),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.chosen_slot    (result.chosen_slot),
		.granted_time   (result.granted_time),
		.remaining_time (result.remaining_time),
		.cpu_time_used  (result.cpu_time_used),
		.dispatch_count (result.dispatch_count),
		.new_priority   (result.new_priority),
		.task_finished  (result.task_finished),
		.nothing_to_run (result.nothing_to_run)
	);

endmodule

/* dv/tb_aging_priority_slice_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_aging_priority_slice_scheduler
// Drives load and dispatch items into the scheduler with random gaps and
// result back-pressure. It keeps a shadow task table and config and checks
// every result, field by field, in order, against the shadow prediction.
// ----------------------------------------------------------------------------
module tb_aging_priority_slice_scheduler;
	import asps_pkg::*;

	localparam int N_SLOTS      = MAX_TASKS_DEF;
	localparam int DRAIN_CYCLES = N_SLOTS + 6;
	localparam int RANDOM_ITEMS = 1030;
	localparam int IDLE_PCT     = 35;

	// index 3 has no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic [TIME_W-1:0] granted_time;
		logic [TIME_W-1:0] remaining_time;
		logic [TIME_W-1:0] cpu_time_used;
		logic [CNT_W-1:0]  dispatch_count;
		logic [PRIO_W-1:0] new_priority;
		logic              task_finished;
		logic              nothing_to_run;
	} dispatch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic out_ready = 1'b0;
	bit steady = 1'b0;
	int errors = 0;
	int items_sent = 0;

	dispatch_result_t grant_q[$];
	dispatch_result_t want_r;

	// shadow task table and config
	logic [1:0]         slot_state [N_SLOTS];
	logic [TIME_W-1:0]  need_tab [N_SLOTS];
	logic [TIME_W-1:0]  left_tab [N_SLOTS];
	logic [TIME_W-1:0]  used_tab [N_SLOTS];
	logic [CNT_W-1:0]   runs_tab [N_SLOTS];
	int                 prio_tab [N_SLOTS];
	logic [BASE_W-1:0]  base_reg;
	logic [SLICE_W-1:0] slice_reg;
	logic [STEP_W-1:0]  step_reg;

	always #5 clk = ~clk;

	asps_in_if  task_if();
	asps_out_if result_if();
	asps_cfg_if cfg_if();

	assign result_if.ready = out_ready;

	aging_priority_slice_scheduler #(.MAX_TASKS(N_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.task_in(task_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	function automatic int sat16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic void load_slot(logic [SLOT_W-1:0] s, logic [TIME_W-1:0] n);
		slot_state[s] = ST_WAIT;
		need_tab[s] = n;
		left_tab[s] = n;
		used_tab[s] = '0;
		runs_tab[s] = '0;
		prio_tab[s] = sat16(int'(base_reg) - int'(n));
	endfunction

	function automatic bit any_waiting();
		for (int i = 0; i < N_SLOTS; i++)
			if (slot_state[i] == ST_WAIT) return 1'b1;
		return 1'b0;
	endfunction

	function automatic dispatch_result_t pick_and_grant();
		dispatch_result_t r;
		int best;
		int slice;
		logic [TIME_W-1:0] granted;
		logic fin;
		r = '0;
		best = -1;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_state[i] != ST_WAIT) continue;
			if (best < 0 || prio_tab[i] > prio_tab[best] ||
				(prio_tab[i] == prio_tab[best] && left_tab[i] < left_tab[best]))
				best = i;
		end
		if (best < 0) begin
			r.nothing_to_run = 1'b1;
			return r;
		end
		slice = (slice_reg == '0) ? 1 : int'(slice_reg);
		if (int'(left_tab[best]) > slice) begin
			granted = slice[TIME_W-1:0];
			left_tab[best] = left_tab[best] - slice[TIME_W-1:0];
			used_tab[best] = used_tab[best] + slice[TIME_W-1:0];
			prio_tab[best] = sat16(prio_tab[best] - int'(step_reg));
			fin = 1'b0;
		end else begin
			// last slice: priority is kept, used time snaps to the full need
			granted = left_tab[best];
			left_tab[best] = '0;
			used_tab[best] = need_tab[best];
			slot_state[best] = ST_DONE;
			fin = 1'b1;
		end
		if (runs_tab[best] != 8'hFF) runs_tab[best]++;
		r.chosen_slot    = best[SLOT_W-1:0];
		r.granted_time   = granted;
		r.remaining_time = left_tab[best];
		r.cpu_time_used  = used_tab[best];
		r.dispatch_count = runs_tab[best];
		r.new_priority   = 16'(prio_tab[best]);
		r.task_finished  = fin;
		return r;
	endfunction

	function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_PRIORITY_BASE: base_reg = d;
			REG_TIME_SLICE: slice_reg = d[SLICE_W-1:0];
			REG_AGING_STEP: step_reg = d[STEP_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_need();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return TIME_W'($urandom_range(0, 24));
		if (r < 96) return TIME_W'($urandom_range(0, 255));
		return 8'hFF;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_if.valid === 1'b1 && out_ready) begin
			if (grant_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none actual slot %0d",
					$time, result_if.chosen_slot);
			end else begin
				want_r = grant_q.pop_front();
				check_field("chosen_slot", 16'(want_r.chosen_slot), 16'(result_if.chosen_slot));
				check_field("granted_time", 16'(want_r.granted_time),
					16'(result_if.granted_time));
				check_field("remaining_time", 16'(want_r.remaining_time),
					16'(result_if.remaining_time));
				check_field("cpu_time_used", 16'(want_r.cpu_time_used),
					16'(result_if.cpu_time_used));
				check_field("dispatch_count", 16'(want_r.dispatch_count),
					16'(result_if.dispatch_count));
				check_field("new_priority", want_r.new_priority, result_if.new_priority);
				check_field("task_finished", 16'(want_r.task_finished),
					16'(result_if.task_finished));
				check_field("nothing_to_run", 16'(want_r.nothing_to_run),
					16'(result_if.nothing_to_run));
			end
		end
	end

	always @(posedge clk) out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	// valid is left high after a handshake; the next call either drops it or
	// replaces the item in the same step
	task automatic send_item(logic m, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] n);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			task_if.valid <= 1'b0;
			@(posedge clk);
		end
		task_if.valid     <= 1'b1;
		task_if.mode      <= m;
		task_if.slot      <= s;
		task_if.need_time <= n;
		do @(posedge clk); while (task_if.ready !== 1'b1);
		if (m == MODE_LOAD)
			load_slot(s, n);
		else
			grant_q.push_back(pick_and_grant());
		items_sent++;
	endtask

	task automatic dispatch();
		send_item(MODE_DISPATCH, SLOT_W'($urandom_range(0, 15)), TIME_W'($urandom_range(0, 255)));
	endtask

	// sender holds off until every result is back and the last item has settled
	task automatic quiesce();
		task_if.valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		set_reg(idx, d);
		@(posedge clk);
	endtask

	// upper data bits of the 4-bit registers are junk and must be dropped
	task automatic write_config(logic [7:0] base, logic [3:0] slice, logic [3:0] step);
		write_reg(REG_PRIORITY_BASE, base);
		write_reg(REG_TIME_SLICE, {4'($urandom_range(0, 15)), slice});
		write_reg(REG_AGING_STEP, {4'($urandom_range(0, 15)), step});
	endtask

	task automatic test_empty_table();
		dispatch();
	endtask

	task automatic test_load_and_dispatch();
		send_item(MODE_LOAD, 4'd0, 8'd0);
		send_item(MODE_LOAD, 4'd15, 8'd255);
		send_item(MODE_LOAD, 4'd5, 8'd10);
		send_item(MODE_LOAD, 4'd7, 8'd10);
		dispatch();                           // zero need finishes at once
		dispatch();                           // equal priority, lower index
		send_item(MODE_LOAD, 4'd2, 8'd13);
		dispatch();
		dispatch();                           // equal priority, less time left wins
		send_item(MODE_LOAD, 4'd5, 8'd3);     // reload over a waiting slot
		dispatch();
		dispatch();
	endtask

	task automatic test_config_extremes();
		quiesce();
		write_reg(REG_PRIORITY_BASE, 8'd255);
		write_reg(REG_TIME_SLICE, 8'hA0);     // slice of zero acts as one
		write_reg(REG_AGING_STEP, 8'h0F);
		write_reg(REG_UNUSED, 8'hFF);
		send_item(MODE_LOAD, 4'd1, 8'd255);
		send_item(MODE_LOAD, 4'd3, 8'd1);
		repeat (3) dispatch();
		quiesce();
		write_reg(REG_PRIORITY_BASE, 8'd0);
		write_reg(REG_TIME_SLICE, 8'h5F);
		write_reg(REG_AGING_STEP, 8'h00);
		send_item(MODE_LOAD, 4'd4, 8'd200);
		repeat (3) dispatch();
	endtask

	task automatic test_random_traffic();
		int target;
		int phase;
		int r;
		logic [7:0] base;
		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			quiesce();
			steady = (phase % 6 == 3);
			r = $urandom_range(0, 99);
			base = (r < 20) ? 8'd0 : (r < 40) ? 8'd255 : 8'($urandom_range(0, 255));
			write_config(base, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 99) < 15)
				write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 75) begin
				// fill some slots, dispatch until the table runs dry or the item budget is spent, then one more dispatch
				repeat ($urandom_range(1, 8))
					send_item(MODE_LOAD, SLOT_W'($urandom_range(0, 15)), pick_need());
				while (any_waiting() && items_sent < target) begin
					if ($urandom_range(0, 99) < 8)
						send_item(MODE_LOAD, SLOT_W'($urandom_range(0, 15)), pick_need());
					else
						dispatch();
				end
				dispatch();
			end else begin
				repeat ($urandom_range(10, 40)) begin
					if ($urandom_range(0, 1) == 0)
						send_item(MODE_LOAD, SLOT_W'($urandom_range(0, 15)), pick_need());
					else
						dispatch();
				end
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		task_if.valid     <= 1'b0;
		task_if.mode      <= MODE_LOAD;
		task_if.slot      <= '0;
		task_if.need_time <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= '0;
		cfg_if.data       <= '0;
		base_reg  = PRIORITY_BASE_RST;
		slice_reg = TIME_SLICE_RST;
		step_reg  = AGING_STEP_RST;
		for (int i = 0; i < N_SLOTS; i++) slot_state[i] = ST_EMPTY;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_load_and_dispatch();
		test_config_extremes();
		test_random_traffic();

		quiesce();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
